>>> hdl/nbc_pkg.sv
// Shared types, constants and coefficient table of the 60 Hz notch filter.
package nbc_pkg;

  // Width of the delay registers and section results.
  localparam int HIST_W = 24;
  // Integer bits of a section accumulator after the fraction bits are dropped.
  localparam int ACC_HEAD = 27;
  // Coefficient table layout.
  localparam int ROM_SECTIONS = 8;
  localparam int N_TERMS = 5;
  localparam int ROM_FRAC = 30;

  typedef logic signed [HIST_W-1:0] hist_t;
  typedef logic [2:0] step_t;

  // Multiply-accumulate steps of one section, in order.
  localparam step_t STEP_B0 = 3'd0;
  localparam step_t STEP_B1 = 3'd1;
  localparam step_t STEP_B2 = 3'd2;
  localparam step_t STEP_A1 = 3'd3;
  localparam step_t STEP_A2 = 3'd4;
  localparam step_t STEP_FIN = 3'd5;

  localparam hist_t HIST_MAX = 24'sh7fffff;
  localparam hist_t HIST_MIN = 24'sh800000;

  // Link between neighbouring cells: one item with its clip flag.
  typedef struct packed {
    logic  valid;
    logic  sat;
    hist_t data;
  } link_t;

  // Q2.30 coefficients per section: b0, b1, b2, a1, a2 (a terms negated).
  localparam logic signed [31:0] COEF_ROM [ROM_SECTIONS][N_TERMS] = '{
    '{32'sd950984448, 32'sd588030848, 32'sd950984448, -32'sd628156224, -32'sd1010316160},
    '{32'sd1073741824, 32'sd663936576, 32'sd1073741824, -32'sd660515968, -32'sd1010641024},
    '{32'sd1073741824, 32'sd663936576, 32'sd1073741824, -32'sd604695744, -32'sd1026751232},
    '{32'sd1073741824, 32'sd663936576, 32'sd1073741824, -32'sd693697600, -32'sd1027410816},
    '{32'sd1073741824, 32'sd663936576, 32'sd1073741824, -32'sd596459712, -32'sd1056262208},
    '{32'sd1073741824, 32'sd663936576, 32'sd1073741824, -32'sd719506880, -32'sd1056600960},
    '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
  };

  // Coefficient rounded half up from Q2.30 to the given number of fraction bits.
  function automatic logic signed [31:0] coef_q(input int sec, input int k, input int frac);
    logic signed [63:0] v;
    v = 64'(COEF_ROM[sec][k]);
    if (frac < ROM_FRAC) begin
      v = v + (64'sd1 <<< (ROM_FRAC - frac - 1));
      v = v >>> (ROM_FRAC - frac);
    end
    return v[31:0];
  endfunction

endpackage

>>> hdl/nbc_cell.sv
// One biquad section: its delay registers and a shared multiply-accumulate unit.
module nbc_cell
  import nbc_pkg::*;
#(
  parameter int SEC_IDX = 0,
  parameter int COEFF_FRAC_BITS = 22
) (
  input  logic  clk,
  input  logic  rst_n,
  input  link_t up_i,
  output logic  up_ready_o,
  output link_t dn_o,
  input  logic  dn_ready_i
);

  localparam int CW = COEFF_FRAC_BITS + 2;
  localparam int PW = CW + HIST_W;
  localparam int AW = COEFF_FRAC_BITS + ACC_HEAD;
  localparam logic signed [AW-1:0] HALF =
    {{(AW - COEFF_FRAC_BITS){1'b0}}, 1'b1, {(COEFF_FRAC_BITS - 1){1'b0}}};
  localparam logic signed [ACC_HEAD-1:0] Y_MAX = ACC_HEAD'(HIST_MAX);
  localparam logic signed [ACC_HEAD-1:0] Y_MIN = ACC_HEAD'(HIST_MIN);

  // Delay line of the section, cleared at reset.
  hist_t x1_r, x2_r, y1_r, y2_r;
  // Sequencing of the item in work.
  logic  busy_r;
  step_t step_r;
  hist_t x_r;
  logic  sat_r;
  // Datapath registers.
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  // Result held for the next cell.
  logic  dn_valid_r;
  logic  dn_sat_r;
  hist_t dn_data_r;

  logic signed [31:0]   coef_full [N_TERMS];
  logic signed [31:0]   coef_w;
  logic signed [CW-1:0] coef_sel;
  hist_t                opnd_sel;
  logic signed [PW-1:0] prod_nxt;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] sum;
  logic signed [ACC_HEAD-1:0] y_wide;
  hist_t                y_nxt;
  logic                 clip_nxt;
  logic                 take;
  logic                 finish;

  // Constant coefficients of this section.
  for (genvar k = 0; k < N_TERMS; k++) begin : g_coef
    assign coef_full[k] = coef_q(SEC_IDX, k, COEFF_FRAC_BITS);
  end

  // Operand and coefficient for the current step.
  always_comb begin
    coef_w = '0;
    opnd_sel = '0;
    unique case (step_r)
      STEP_B0: begin coef_w = coef_full[0]; opnd_sel = x_r;  end
      STEP_B1: begin coef_w = coef_full[1]; opnd_sel = x1_r; end
      STEP_B2: begin coef_w = coef_full[2]; opnd_sel = x2_r; end
      STEP_A1: begin coef_w = coef_full[3]; opnd_sel = y1_r; end
      STEP_A2: begin coef_w = coef_full[4]; opnd_sel = y2_r; end
      default: begin coef_w = '0; opnd_sel = '0; end
    endcase
    coef_sel = coef_w[CW-1:0];
    prod_nxt = coef_sel * opnd_sel;
  end

  // Final sum; dropping the fraction bits floors, the half already in acc rounds.
  always_comb begin
    prod_ext = {{(AW - PW){prod_r[PW-1]}}, prod_r};
    sum = acc_r + prod_ext;
    y_wide = sum[AW-1:COEFF_FRAC_BITS];
    clip_nxt = 1'b0;
    y_nxt = y_wide[HIST_W-1:0];
    if (y_wide > Y_MAX) begin
      y_nxt = HIST_MAX;
      clip_nxt = 1'b1;
    end else if (y_wide < Y_MIN) begin
      y_nxt = HIST_MIN;
      clip_nxt = 1'b1;
    end
  end

  assign up_ready_o = !busy_r;
  assign take = up_i.valid && !busy_r;
  assign finish = busy_r && (step_r == STEP_FIN) && (!dn_valid_r || dn_ready_i);

  // Control state and delay line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_B0;
      dn_valid_r <= 1'b0;
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else begin
      if (take) begin
        busy_r <= 1'b1;
        step_r <= STEP_B0;
      end else if (finish) begin
        busy_r <= 1'b0;
        step_r <= STEP_B0;
        x2_r <= x1_r;
        x1_r <= x_r;
        y2_r <= y1_r;
        y1_r <= y_nxt;
      end else if (busy_r && step_r != STEP_FIN) begin
        step_r <= step_r + 3'd1;
      end
      if (finish) begin
        dn_valid_r <= 1'b1;
      end else if (dn_ready_i) begin
        dn_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (take) begin
      x_r <= up_i.data;
      sat_r <= up_i.sat;
    end
    if (busy_r && step_r != STEP_FIN) begin
      prod_r <= prod_nxt;
    end
    if (busy_r && step_r == STEP_B1) begin
      acc_r <= prod_ext + HALF;
    end else if (busy_r && step_r != STEP_B0 && step_r != STEP_FIN) begin
      acc_r <= sum;
    end
    if (finish) begin
      dn_data_r <= y_nxt;
      dn_sat_r <= sat_r | clip_nxt;
    end
  end

  assign dn_o.valid = dn_valid_r;
  assign dn_o.sat = dn_sat_r;
  assign dn_o.data = dn_data_r;

endmodule

>>> hdl/notch_biquad_cascade_60hz_top.sv
// Top level of the 60 Hz notch filter: a chain of biquad cells and the output stage.
//
//   channel   ports                              direction
//   input     in_valid, in_stall, in_sample_in   item in, in_stall driven here
//   result    out_valid, out_stall, out_sample_out, out_saturated   item out
//
// Each cell works on one item at a time: five multiplies through its own
// multiplier, then a final step to round and clip, which waits while the
// next cell still holds its last result. A cell takes its next item only
// once it has gone idle, so it never starts an item before the last is done.
// Synchronous reset clears all delay registers and handshake state.
// A stall on the result side backs up from cell to cell to in_stall.
module notch_biquad_cascade_60hz_top
  import nbc_pkg::*;
#(
  parameter int SECTIONS = 6,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_FRAC_BITS = 22
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_sample_out,
  output logic                   out_saturated
);

  localparam hist_t S_MAX = HIST_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam hist_t S_MIN = HIST_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  link_t lnk [SECTIONS+1];
  logic  rdy [SECTIONS+1];

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic                   out_sat_r;
  logic                   out_ready;
  hist_t                  last_data;
  hist_t                  clamp_data;
  logic                   clamp_clip;

  // Incoming item, sign-extended to the delay register width.
  assign lnk[0].valid = in_valid;
  assign lnk[0].sat = 1'b0;
  assign lnk[0].data = {{(HIST_W - SAMPLE_BITS){in_sample_in[SAMPLE_BITS-1]}}, in_sample_in};
  assign in_stall = !rdy[0];

  // Chain of section cells.
  for (genvar s = 0; s < SECTIONS; s++) begin : g_cell
    nbc_cell #(
      .SEC_IDX(s),
      .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .up_i(lnk[s]),
      .up_ready_o(rdy[s]),
      .dn_o(lnk[s+1]),
      .dn_ready_i(rdy[s+1])
    );
  end

  // Clip the last section result to the sample range.
  always_comb begin
    last_data = lnk[SECTIONS].data;
    clamp_data = last_data;
    clamp_clip = 1'b0;
    if (last_data > S_MAX) begin
      clamp_data = S_MAX;
      clamp_clip = 1'b1;
    end else if (last_data < S_MIN) begin
      clamp_data = S_MIN;
      clamp_clip = 1'b1;
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign rdy[SECTIONS] = out_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= lnk[SECTIONS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && lnk[SECTIONS].valid) begin
      out_sample_r <= clamp_data[SAMPLE_BITS-1:0];
      out_sat_r <= lnk[SECTIONS].sat | clamp_clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated = out_sat_r;

endmodule
